[hdl/tbpr_pkg.sv]
// shared types and constants of the tile background pixel renderer
`timescale 1ns / 1ps

package tbpr_pkg;

	localparam logic [1:0] MODE_VRAM_WR  = 2'd0;
	localparam logic [1:0] MODE_PAL_WR   = 2'd1;
	localparam logic [1:0] MODE_HIT_CLR  = 2'd2;
	localparam logic [1:0] MODE_RENDER   = 2'd3;

	localparam logic [2:0] CFG_SCROLL_X   = 3'd0;
	localparam logic [2:0] CFG_SCROLL_Y   = 3'd1;
	localparam logic [2:0] CFG_NT_X       = 3'd2;
	localparam logic [2:0] CFG_BG_HALF    = 3'd3;
	localparam logic [2:0] CFG_SPR_HALF   = 3'd4;
	localparam logic [2:0] CFG_SPR0_Y     = 3'd5;
	localparam logic [2:0] CFG_SPR0_TILE  = 3'd6;
	localparam logic [2:0] CFG_SPR0_X     = 3'd7;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int BANK_AW     = 12;
	localparam int BANK_DEPTH  = 4096;
	localparam int NT_AW       = 11;
	localparam int NT_DEPTH    = 2048;
	localparam int PAL_DEPTH   = 16;

	typedef struct packed {
		logic [1:0]  mode;
		logic [13:0] address;
		logic [7:0]  data;
		logic [7:0]  line;
		logic [7:0]  column;
	} req_t;

	typedef struct packed {
		logic [7:0] color;
		logic       opaque;
		logic       sprite0_hit;
	} res_t;

endpackage

[hdl/tile_background_pixel_render.sv]
// top level of the tile background pixel renderer
`timescale 1ns / 1ps

// One request per clock is taken in mode 0 to 3 unless a result waits under stall; a render
// request has the name table read at the taking edge, then the pattern read, then the palette
// lookup into the result register. The pace is set by the pattern store, which is split into
// two bit-plane banks that are each read at two addresses per cycle, one for the background
// pixel and one for the sprite-0 row. The name table memory is read at two addresses per
// cycle (tile and attribute). The whole pipeline holds while a result waits under stall. No
// store is cleared after reset; the hit flag resets to zero.
module tile_background_pixel_render (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  tbpr_pkg::req_t                  req,
	output logic                            res_valid,
	input  logic                            res_stall,
	output tbpr_pkg::res_t                  res
);
	import tbpr_pkg::*;

	logic [7:0] scroll_x_q, scroll_y_q, spr0_y_q, spr0_tile_q, spr0_x_q;
	logic       nt_x_q, bg_half_q, spr_half_q;

	logic [7:0] nt_mem [NT_DEPTH];
	logic [7:0] pat0_mem [BANK_DEPTH];
	logic [7:0] pat1_mem [BANK_DEPTH];
	logic [7:0] pal_q [PAL_DEPTH];

	logic        adv;
	logic        take;
	logic [9:0]  wide_x;
	logic [7:0]  px, py;
	logic [NT_AW-1:0] tile_addr, attr_addr;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [13:0] address_s1;
	logic [7:0]  data_s1, line_s1, column_s1;
	logic [2:0]  fine_x_s1, fine_y_s1;
	logic [1:0]  quad_s1;
	logic [7:0]  tile_s1, attr_s1;

	logic [7:0]  spr_top, spr_dy, spr_dx;
	logic        spr_in;
	logic [BANK_AW-1:0] bg_addr, sp_addr, wr_bank_addr;
	logic [1:0]  high;

	logic        valid_s2;
	logic [1:0]  mode_s2;
	logic [3:0]  pal_addr_s2;
	logic [7:0]  data_s2;
	logic [2:0]  fine_x_s2, spr_off_s2;
	logic [1:0]  high_s2;
	logic        col_last_s2, spr_in_s2;
	logic [7:0]  bg0_s2, bg1_s2, sp0_s2, sp1_s2;

	logic        b0, b1, opq, row_bit, hit_d;
	logic [3:0]  pal_idx;
	logic        hit_q;
	logic        res_valid_q;
	res_t        res_q;

	assign adv       = !(res_valid_q && res_stall);
	assign req_stall = !adv;
	assign take      = req_valid && adv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_x_q  <= '0;
			scroll_y_q  <= '0;
			nt_x_q      <= 1'b0;
			bg_half_q   <= 1'b0;
			spr_half_q  <= 1'b0;
			spr0_y_q    <= '0;
			spr0_tile_q <= '0;
			spr0_x_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCROLL_X:  scroll_x_q  <= cfg_data;
				CFG_SCROLL_Y:  scroll_y_q  <= cfg_data;
				CFG_NT_X:      nt_x_q      <= cfg_data[0];
				CFG_BG_HALF:   bg_half_q   <= cfg_data[0];
				CFG_SPR_HALF:  spr_half_q  <= cfg_data[0];
				CFG_SPR0_Y:    spr0_y_q    <= cfg_data;
				CFG_SPR0_TILE: spr0_tile_q <= cfg_data;
				CFG_SPR0_X:    spr0_x_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	// stage 0: scroll and name table addresses
	always_comb begin
		wide_x    = {2'b00, scroll_x_q} + {1'b0, nt_x_q, 8'h00} + {2'b00, req.column};
		px        = wide_x[7:0];
		py        = req.line + scroll_y_q;
		tile_addr = {wide_x[8], py[7:3], px[7:3]};
		attr_addr = {wide_x[8], 4'b1111, py[7:5], px[7:5]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tile_s1 <= nt_mem[tile_addr];
			attr_s1 <= nt_mem[attr_addr];
			if (take && req.mode == MODE_VRAM_WR && req.address[13] &&
				req.address[12:11] == 2'b00) begin
				nt_mem[req.address[NT_AW-1:0]] <= req.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1    <= req.mode;
			address_s1 <= req.address;
			data_s1    <= req.data;
			line_s1    <= req.line;
			column_s1  <= req.column;
			fine_x_s1  <= px[2:0];
			fine_y_s1  <= py[2:0];
			quad_s1    <= {py[4], px[4]};
		end
	end

	// stage 1: pattern addresses and sprite row window
	always_comb begin
		spr_top      = spr0_y_q + 8'd1;
		spr_dy       = line_s1 - spr_top;
		spr_dx       = column_s1 - spr0_x_q;
		spr_in       = (line_s1 >= spr_top) && (spr_dy[7:3] == 5'd0) &&
			(column_s1 >= spr0_x_q) && (spr_dx[7:3] == 5'd0);
		bg_addr      = {bg_half_q, tile_s1, fine_y_s1};
		sp_addr      = {spr_half_q, spr0_tile_q, spr_dy[2:0]};
		wr_bank_addr = {address_s1[12:4], address_s1[2:0]};
		case (quad_s1)
			2'd0:    high = attr_s1[1:0];
			2'd1:    high = attr_s1[3:2];
			2'd2:    high = attr_s1[5:4];
			default: high = attr_s1[7:6];
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bg0_s2 <= pat0_mem[bg_addr];
			sp0_s2 <= pat0_mem[sp_addr];
			bg1_s2 <= pat1_mem[bg_addr];
			sp1_s2 <= pat1_mem[sp_addr];
			if (valid_s1 && mode_s1 == MODE_VRAM_WR && !address_s1[13]) begin
				if (address_s1[3]) begin
					pat1_mem[wr_bank_addr] <= data_s1;
				end else begin
					pat0_mem[wr_bank_addr] <= data_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2     <= mode_s1;
			pal_addr_s2 <= address_s1[3:0];
			data_s2     <= data_s1;
			fine_x_s2   <= fine_x_s1;
			high_s2     <= high;
			col_last_s2 <= (column_s1 == 8'hFF);
			spr_in_s2   <= spr_in;
			spr_off_s2  <= spr_dx[2:0];
		end
	end

	// stage 2: pixel, palette and hit test
	always_comb begin
		b0      = bg0_s2[~fine_x_s2];
		b1      = bg1_s2[~fine_x_s2];
		opq     = b0 | b1;
		row_bit = sp0_s2[~spr_off_s2] | sp1_s2[~spr_off_s2];
		pal_idx = {high_s2, b1, b0};
		if (pal_idx[1:0] == 2'b00) begin
			pal_idx = 4'd0;
		end
		hit_d = hit_q;
		if (valid_s2 && mode_s2 == MODE_HIT_CLR) begin
			hit_d = 1'b0;
		end else if (valid_s2 && mode_s2 == MODE_RENDER && opq && !col_last_s2 &&
			spr_in_s2 && row_bit) begin
			hit_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && mode_s2 == MODE_PAL_WR) begin
			pal_q[pal_addr_s2] <= data_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.color       <= pal_q[pal_idx];
			res_q.opaque      <= opq;
			res_q.sprite0_hit <= hit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			hit_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= take;
			valid_s2    <= valid_s1;
			hit_q       <= hit_d;
			res_valid_q <= valid_s2 && mode_s2 == MODE_RENDER;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> ($stable(valid_s2) && $stable(valid_s1)))
		else $error("pipeline moved while result held");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_q) |-> $past(valid_s2 && mode_s2 == MODE_RENDER && adv))
		else $error("hit flag set without a render");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && mode_s2 == MODE_HIT_CLR) |=> !hit_q)
		else $error("hit flag not cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s2 && mode_s2 == MODE_RENDER))
		else $error("result without a render request");
`endif

endmodule

[tb/sv/tb.sv]
// self-checking testbench of the tile background pixel renderer with its pixel scoreboard
`timescale 1ns / 1ps

module tb;
	import tbpr_pkg::*;

	class pixel_scoreboard;
		bit [7:0] pattern [8192];
		bit [7:0] names [2048];
		bit [7:0] palette [16];
		bit pat_set [8192];
		bit name_set [2048];
		bit hit;
		bit [7:0] scroll_x, scroll_y, spr_y, spr_tile, spr_x;
		bit nt_x, bg_half, spr_half;
		res_t pixels_due [$];
		int mismatches, pixels_seen, hits_seen;

		function void set_reg(logic [2:0] idx, logic [7:0] v);
			case (idx)
				CFG_SCROLL_X:  scroll_x = v;
				CFG_SCROLL_Y:  scroll_y = v;
				CFG_NT_X:      nt_x = v[0];
				CFG_BG_HALF:   bg_half = v[0];
				CFG_SPR_HALF:  spr_half = v[0];
				CFG_SPR0_Y:    spr_y = v;
				CFG_SPR0_TILE: spr_tile = v;
				CFG_SPR0_X:    spr_x = v;
				default: ;
			endcase
		endfunction

		function void place(input bit [7:0] ln, input bit [7:0] col,
				output bit [7:0] px, output bit [7:0] py, output int tbase);
			bit [8:0] wide;
			wide = {1'b0, scroll_x} + {nt_x, 8'h00} + {1'b0, col};
			px = wide[7:0];
			py = scroll_y + ln;
			tbase = wide[8] ? 1024 : 0;
		endfunction

		function int tile_slot(bit [7:0] ln, bit [7:0] col);
			bit [7:0] px, py;
			int tb;
			place(ln, col, px, py, tb);
			return tb + int'(px[7:3]) + int'(py[7:3]) * 32;
		endfunction

		function int attr_slot(bit [7:0] ln, bit [7:0] col);
			bit [7:0] px, py;
			int tb;
			place(ln, col, px, py, tb);
			return tb + 960 + int'(px[7:5]) + int'(py[7:5]) * 8;
		endfunction

		// low plane byte of the background row; the high plane sits 8 bytes on
		function int row_addr(bit [7:0] ln, bit [7:0] col);
			bit [7:0] px, py;
			int tb;
			place(ln, col, px, py, tb);
			return int'(bg_half) * 4096 + int'(names[tile_slot(ln, col)]) * 16 + int'(py[2:0]);
		endfunction

		function void note_request(req_t r);
			bit [7:0] px, py, attr, row;
			bit [2:0] sh;
			bit [1:0] hi;
			bit [3:0] pidx;
			bit b0, b1;
			int tb, pb, top, ln, col, left, spr_addr;
			res_t e;
			case (r.mode)
				MODE_VRAM_WR: begin
					if (r.address < 14'd8192) begin
						pattern[r.address] = r.data;
						pat_set[r.address] = 1'b1;
					end else if (r.address < 14'd10240) begin
						names[r.address - 14'd8192] = r.data;
						name_set[r.address - 14'd8192] = 1'b1;
					end
				end
				MODE_PAL_WR: palette[r.address[3:0]] = r.data;
				MODE_HIT_CLR: hit = 1'b0;
				MODE_RENDER: begin
					place(r.line, r.column, px, py, tb);
					pb = row_addr(r.line, r.column);
					sh = ~px[2:0];
					b0 = pattern[pb][sh];
					b1 = pattern[pb + 8][sh];
					attr = names[attr_slot(r.line, r.column)];
					hi = 2'(attr >> {py[4], px[4], 1'b0});
					// transparent pixels all read the shared backdrop entry
					pidx = (b0 | b1) ? {hi, b1, b0} : 4'd0;
					e.color = palette[pidx];
					e.opaque = b0 | b1;
					if (!hit && e.opaque && r.column != 8'd255) begin
						top = (int'(spr_y) + 1) & 255;
						ln = int'(r.line);
						col = int'(r.column);
						left = int'(spr_x);
						if (top <= ln && top + 8 > ln && col >= left && col - left < 8) begin
							spr_addr = int'(spr_half) * 4096 + int'(spr_tile) * 16
								+ (ln - top);
							row = pattern[spr_addr] | pattern[spr_addr + 8];
							if (row[7 - (col - left)])
								hit = 1'b1;
						end
					end
					e.sprite0_hit = hit;
					pixels_due.push_back(e);
				end
				default: ;
			endcase
		endfunction

		function void check_pixel(res_t got);
			res_t exp;
			if (pixels_due.size() == 0) begin
				$display("%0t pixel with none pending: expected nothing, %s %h opaque %b hit %b",
					$time, "actual color", got.color, got.opaque, got.sprite0_hit);
				mismatches++;
				return;
			end
			exp = pixels_due.pop_front();
			pixels_seen++;
			if (got.sprite0_hit === 1'b1)
				hits_seen++;
			if (got.color !== exp.color) begin
				$display("%0t color: expected %h actual %h", $time, exp.color, got.color);
				mismatches++;
			end
			if (got.opaque !== exp.opaque) begin
				$display("%0t opaque: expected %b actual %b", $time, exp.opaque, got.opaque);
				mismatches++;
			end
			if (got.sprite0_hit !== exp.sprite0_hit) begin
				$display("%0t sprite0_hit: expected %b actual %b", $time, exp.sprite0_hit,
					got.sprite0_hit);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	bit calm;
	bit hold_req;
	int sent;
	int settings;
	pixel_scoreboard sb = new;

	always #4 clk = ~clk;

	tile_background_pixel_render dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_pixel(res);
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else begin
				res_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb: errors");
		$finish;
	end

	task automatic send_req(input req_t r);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		sent++;
	endtask

	function automatic req_t noise_req(logic [1:0] mode);
		req_t r;
		r.mode = mode;
		r.address = 14'($urandom);
		r.data = 8'($urandom);
		r.line = 8'($urandom);
		r.column = 8'($urandom);
		return r;
	endfunction

	task automatic send_vram(input int addr, input logic [7:0] val);
		req_t r;
		r = noise_req(MODE_VRAM_WR);
		r.address = 14'(addr);
		r.data = val;
		send_req(r);
	endtask

	task automatic send_palette(input logic [13:0] addr, input logic [7:0] val);
		req_t r;
		r = noise_req(MODE_PAL_WR);
		r.address = addr;
		r.data = val;
		send_req(r);
	endtask

	task automatic send_clear();
		send_req(noise_req(MODE_HIT_CLR));
	endtask

	// fill any name table or background pattern byte the pixel would read before rendering it
	task automatic render_pixel(input int ln, input int col);
		req_t r;
		int slot, pb;
		slot = sb.tile_slot(8'(ln), 8'(col));
		if (!sb.name_set[slot])
			send_vram(8192 + slot, 8'($urandom));
		slot = sb.attr_slot(8'(ln), 8'(col));
		if (!sb.name_set[slot])
			send_vram(8192 + slot, 8'($urandom));
		pb = sb.row_addr(8'(ln), 8'(col));
		if (!sb.pat_set[pb])
			send_vram(pb, 8'($urandom));
		if (!sb.pat_set[pb + 8])
			send_vram(pb + 8, 8'($urandom));
		r = noise_req(MODE_RENDER);
		r.line = 8'(ln);
		r.column = 8'(col);
		send_req(r);
	endtask

	task automatic cover_sprite_tile();
		int base;
		base = int'(sb.spr_half) * 4096 + int'(sb.spr_tile) * 16;
		for (int k = 0; k < 16; k++) begin
			if (!sb.pat_set[base + k])
				send_vram(base + k, 8'($urandom));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] ntx,
			input logic [7:0] bgh, input logic [7:0] sph, input logic [7:0] s0y,
			input logic [7:0] s0t, input logic [7:0] s0x);
		write_reg(CFG_SCROLL_X, sx);
		write_reg(CFG_SCROLL_Y, sy);
		write_reg(CFG_NT_X, ntx);
		write_reg(CFG_BG_HALF, bgh);
		write_reg(CFG_SPR_HALF, sph);
		write_reg(CFG_SPR0_Y, s0y);
		write_reg(CFG_SPR0_TILE, s0t);
		write_reg(CFG_SPR0_X, s0x);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// wait for the pipeline to drain, including writes that give no pixel
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pixels_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_request();
		int pick, ln, col;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			if ($urandom_range(0, 1) == 1) begin
				ln = ((int'(sb.spr_y) + 1) & 255) + int'($urandom_range(0, 10)) - 1;
				col = int'(sb.spr_x) + int'($urandom_range(0, 10)) - 1;
			end else begin
				ln = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 255)
					: $urandom_range(0, 239);
				col = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 255);
			end
			if (ln < 0) ln = 0;
			if (ln > 255) ln = 255;
			if (col < 0) col = 0;
			if (col > 255) col = 255;
			render_pixel(ln, col);
		end else if (pick < 70) begin
			send_clear();
		end else if (pick < 90) begin
			send_vram($urandom_range(0, 16383), 8'($urandom));
		end else begin
			send_palette(14'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int goal;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
		for (int i = 0; i < 16; i++)
			send_palette(14'(i), 8'(i * 17));
		cover_sprite_tile();
		send_vram(10240, 8'hff);
		send_vram(16383, 8'h00);
		send_vram(8191, 8'h00);
		send_vram(8192, 8'h00);
		send_vram(10239, 8'hff);
		render_pixel(0, 0);
		render_pixel(0, 255);
		render_pixel(3, 3);
		render_pixel(7, 7);
		render_pixel(239, 0);
		render_pixel(239, 255);
		render_pixel(240, 128);
		render_pixel(248, 7);
		render_pixel(255, 255);
		send_clear();
		render_pixel(5, 2);

		for (int ph = 0; ph < 7; ph++) begin
			settle();
			case (ph)
				0: apply_setting(8'd255, 8'd255, 8'd1, 8'd1, 8'd1, 8'd239, 8'd255, 8'd248);
				1: apply_setting(8'd128, 8'd16, 8'd0, 8'd0, 8'd1, 8'd250, 8'($urandom), 8'd252);
				default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom));
			endcase
			if (ph == 1)
				hold_req = 1'b1;
			if (ph == 6)
				calm = 1'b1;
			cover_sprite_tile();
			goal = sent + 240;
			while (sent < goal)
				random_request();
		end

		settle();
		$display("summary: %0d requests taken, %0d pixels checked, %0d with the hit flag set",
			sent, sb.pixels_seen, sb.hits_seen);
		$display("summary: %0d register settings, scroll and sprite extremes included", settings);
		if (sb.mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
